// ===== sv/pbsa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbsa_pkg: packed byte SIMD ALU shared definitions
// Widths, operation codes and item structs used by the ALU modules.
// ----------------------------------------------------------------------------
package pbsa_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned OpW    = 4;
  localparam int unsigned DestW  = 5;
  localparam int unsigned LaneW  = 8;
  localparam int unsigned NLanes = WordW / LaneW;

  localparam logic [LaneW-1:0] LaneMax = 8'hff;

  typedef enum logic [OpW-1:0] {
    OP_STALL  = 4'd0,
    OP_PADD   = 4'd3,
    OP_PADDS  = 4'd4,
    OP_PSUB   = 4'd5,
    OP_PSUBS  = 4'd6,
    OP_PMADD  = 4'd7,
    OP_PACK   = 4'd8,
    OP_CHROMA = 4'd9
  } op_e;

  typedef struct packed {
    logic [WordW-1:0] operand_a;
    logic [WordW-1:0] operand_b;
    logic [OpW-1:0]   operation;
    logic [DestW-1:0] dest_register;
  } in_item_t;

  typedef struct packed {
    logic [WordW-1:0] result;
    logic [DestW-1:0] dest_register_out;
    logic             bad_opcode;
  } out_item_t;

  function automatic logic [LaneW-1:0] sat8(input logic [2*LaneW-1:0] v);
    sat8 = (v > {{LaneW{1'b0}}, LaneMax}) ? LaneMax : v[LaneW-1:0];
  endfunction

endpackage : pbsa_pkg
`default_nettype wire

// ===== sv/pbsa_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbsa_in_if / pbsa_out_if: valid/ready channels of the packed byte SIMD ALU
// Input channel carries operands, opcode and tag; output carries the result.
// ----------------------------------------------------------------------------
interface pbsa_in_if;
  logic                         valid;
  logic                         ready;
  logic [pbsa_pkg::WordW-1:0]   operand_a;
  logic [pbsa_pkg::WordW-1:0]   operand_b;
  logic [pbsa_pkg::OpW-1:0]     operation;
  logic [pbsa_pkg::DestW-1:0]   dest_register;

  modport source (output valid, operand_a, operand_b, operation, dest_register,
                  input ready);
  modport sink   (input valid, operand_a, operand_b, operation, dest_register,
                  output ready);
endinterface : pbsa_in_if

interface pbsa_out_if;
  logic                         valid;
  logic                         ready;
  logic [pbsa_pkg::WordW-1:0]   result;
  logic [pbsa_pkg::DestW-1:0]   dest_register_out;
  logic                         bad_opcode;

  modport source (output valid, result, dest_register_out, bad_opcode,
                  input ready);
  modport sink   (input valid, result, dest_register_out, bad_opcode,
                  output ready);
endinterface : pbsa_out_if
`default_nettype wire

// ===== sv/packed_byte_simd_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// packed_byte_simd_alu: packed byte SIMD execution unit
// Four unsigned byte lanes: wrapping/saturating add and subtract,
// saturating multiply-add, pack and chroma-key compare.
//
//   channel  dir  payload
//   in_i     in   operand_a, operand_b, operation, dest_register
//   out_o    out  result, dest_register_out, bad_opcode
//
// One transfer per cycle sustained while out_o is ready; an item passes the
// input register, then the result register after the lane logic.
// Reset clears both valid flags and the held result word.
// Stalls on out_o back up through the result register into in_i.ready.
// ----------------------------------------------------------------------------
module packed_byte_simd_alu (
  input  logic            clk_i,
  input  logic            rst_ni,
  pbsa_in_if.sink         in_i,
  pbsa_out_if.source      out_o
);
  import pbsa_pkg::*;

  logic                in_valid_q;
  in_item_t            in_item_q;
  logic                out_valid_q;
  out_item_t           out_item_q;
  logic [WordW-1:0]    held_q;
  out_item_t           alu_res;
  logic                out_free;
  logic                advance;

  assign out_free = !out_valid_q || out_o.ready;
  assign advance  = in_valid_q && out_free;
  assign in_i.ready = !in_valid_q || advance;

  pbsa_alu u_alu (
    .item_i (in_item_q),
    .held_i (held_q),
    .res_o  (alu_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      held_q      <= '0;
    end else begin
      if (in_i.ready) in_valid_q <= in_i.valid;
      if (out_free) out_valid_q <= in_valid_q;
      if (advance) held_q <= alu_res.result;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_item_q.operand_a     <= in_i.operand_a;
      in_item_q.operand_b     <= in_i.operand_b;
      in_item_q.operation     <= in_i.operation;
      in_item_q.dest_register <= in_i.dest_register;
    end
    if (advance) out_item_q <= alu_res;
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.result            = out_item_q.result;
  assign out_o.dest_register_out = out_item_q.dest_register_out;
  assign out_o.bad_opcode        = out_item_q.bad_opcode;

endmodule : packed_byte_simd_alu
`default_nettype wire

// ===== sv/pbsa_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbsa_alu: lane datapath of the packed byte SIMD ALU
// Computes one result item from a registered input item and the held word.
// ----------------------------------------------------------------------------
module pbsa_alu (
  input  pbsa_pkg::in_item_t          item_i,
  input  logic [pbsa_pkg::WordW-1:0]  held_i,
  output pbsa_pkg::out_item_t         res_o
);
  import pbsa_pkg::*;

  logic [NLanes-1:0][LaneW-1:0] lane_a;
  logic [NLanes-1:0][LaneW-1:0] lane_b;

  assign lane_a = item_i.operand_a;
  assign lane_b = item_i.operand_b;

  always_comb begin
    logic [NLanes-1:0][LaneW-1:0]   r;
    logic [NLanes-1:0][LaneW-1:0]   prod;
    logic [LaneW:0]                 sum;
    logic [LaneW:0]                 dif;
    logic                           bad;

    r    = held_i;
    bad  = 1'b0;
    sum  = '0;
    dif  = '0;
    prod = '0;
    for (int i = 0; i < NLanes; i++) begin
      prod[i] = sat8({{LaneW{1'b0}}, lane_a[i]} * {{LaneW{1'b0}}, lane_b[i]});
    end

    unique case (op_e'(item_i.operation))
      OP_STALL: r = held_i;
      OP_PADD, OP_PADDS, OP_PSUB, OP_PSUBS, OP_CHROMA: begin
        for (int i = 0; i < NLanes; i++) begin
          sum = {1'b0, lane_a[i]} + {1'b0, lane_b[i]};
          dif = {1'b0, lane_a[i]} - {1'b0, lane_b[i]};
          case (op_e'(item_i.operation))
            OP_PADD:  r[i] = sum[LaneW-1:0];
            OP_PADDS: r[i] = sum[LaneW] ? LaneMax : sum[LaneW-1:0];
            OP_PSUB:  r[i] = dif[LaneW-1:0];
            OP_PSUBS: r[i] = dif[LaneW] ? '0 : dif[LaneW-1:0];
            default:  r[i] = (lane_a[i] == lane_b[i]) ? LaneMax : '0;
          endcase
        end
      end
      OP_PMADD: begin
        r    = '0;
        sum  = {1'b0, prod[3]} + {1'b0, prod[2]};
        r[2] = sum[LaneW] ? LaneMax : sum[LaneW-1:0];
        sum  = {1'b0, prod[1]} + {1'b0, prod[0]};
        r[0] = sum[LaneW] ? LaneMax : sum[LaneW-1:0];
      end
      OP_PACK: begin
        r[3] = lane_b[2];
        r[2] = lane_b[0];
        r[1] = lane_a[2];
        r[0] = lane_a[0];
      end
      default: begin
        r   = held_i;
        bad = 1'b1;
      end
    endcase

    res_o.result            = r;
    res_o.dest_register_out = item_i.dest_register;
    res_o.bad_opcode        = bad;
  end

endmodule : pbsa_alu
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the packed byte SIMD ALU
// Directed lane corner cases, then weighted random instructions through a
// bursty driver; a scoreboard predicts every result, including the held
// word on stall and unknown opcodes, under random and long output stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import pbsa_pkg::*;

  localparam int unsigned RandomItems = 1850;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned LongHold    = 300;
  localparam int unsigned DrainCycles = 20;

  typedef enum int unsigned {SINK_FREE, SINK_HALF, SINK_LIGHT} sink_mode_e;

  logic clk;
  logic rst_n;

  pbsa_in_if  in_ch ();
  pbsa_out_if out_ch ();

  packed_byte_simd_alu u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  in_item_t    pending_instrs[$];
  out_item_t   expected_results[$];
  logic [WordW-1:0] held_word;
  int unsigned err_count;
  int unsigned cycle_count;
  int unsigned instrs_taken;
  bit          in_fire;

  // driver and sink pacing
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned hold_left;
  int unsigned mode_left;
  bit          long_hold_done;
  sink_mode_e  sink_mode;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit is_defined_op(logic [OpW-1:0] op);
    case (op)
      OP_STALL, OP_PADD, OP_PADDS, OP_PSUB, OP_PSUBS, OP_PMADD, OP_PACK, OP_CHROMA:
        return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic int unsigned clamp_byte(int unsigned v);
    return (v > 255) ? 255 : v;
  endfunction

  function automatic out_item_t alu_predict(in_item_t it, logic [WordW-1:0] held);
    out_item_t   r;
    int unsigned x, y, c;
    int unsigned prod[NLanes];
    r.result            = held;
    r.dest_register_out = it.dest_register;
    r.bad_opcode        = 1'b0;
    case (it.operation)
      OP_STALL: ;
      OP_PADD, OP_PADDS, OP_PSUB, OP_PSUBS, OP_CHROMA: begin
        for (int i = 0; i < NLanes; i++) begin
          x = it.operand_a[LaneW*i +: LaneW];
          y = it.operand_b[LaneW*i +: LaneW];
          case (it.operation)
            OP_PADD:  c = (x + y) & 255;
            OP_PADDS: c = clamp_byte(x + y);
            OP_PSUB:  c = (x - y) & 255;
            OP_PSUBS: c = (y > x) ? 0 : x - y;
            default:  c = (x == y) ? 255 : 0;
          endcase
          r.result[LaneW*i +: LaneW] = c[LaneW-1:0];
        end
      end
      OP_PMADD: begin
        for (int i = 0; i < NLanes; i++) begin
          prod[i] = clamp_byte(int'(it.operand_a[LaneW*i +: LaneW])
                               * int'(it.operand_b[LaneW*i +: LaneW]));
        end
        r.result        = '0;
        r.result[23:16] = 8'(clamp_byte(prod[3] + prod[2]));
        r.result[7:0]   = 8'(clamp_byte(prod[1] + prod[0]));
      end
      OP_PACK:
        r.result = {it.operand_b[23:16], it.operand_b[7:0],
                    it.operand_a[23:16], it.operand_a[7:0]};
      default: r.bad_opcode = 1'b1;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [WordW-1:0] got,
                                 logic [WordW-1:0] want);
    $display("[%0t] mismatch %s: got %h want %h", $realtime, what, got, want);
    err_count++;
  endtask

  task automatic add_instr(logic [WordW-1:0] a, logic [WordW-1:0] b,
                           logic [OpW-1:0] op, logic [DestW-1:0] dest);
    in_item_t it;
    it.operand_a     = a;
    it.operand_b     = b;
    it.operation     = op;
    it.dest_register = dest;
    pending_instrs.push_back(it);
  endtask

  function automatic logic [LaneW-1:0] rand_lane();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return LaneMax;
      2:       return 8'($urandom_range(0, 17));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [OpW-1:0] rand_op();
    int unsigned pick;
    logic [OpW-1:0] op;
    pick = $urandom_range(0, 99);
    if (pick < 84) begin
      case ($urandom_range(0, 6))
        0:       op = OP_PADD;
        1:       op = OP_PADDS;
        2:       op = OP_PSUB;
        3:       op = OP_PSUBS;
        4:       op = OP_PMADD;
        5:       op = OP_PACK;
        default: op = OP_CHROMA;
      endcase
    end else if (pick < 92) begin
      op = OP_STALL;
    end else begin
      do op = 4'($urandom); while (is_defined_op(op));
    end
    return op;
  endfunction

  // scoreboard: inputs and outputs sampled at the rising edge
  always @(posedge clk) begin
    out_item_t got, want;
    in_item_t  it;
    in_fire = 1'b0;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        it.operand_a     = in_ch.operand_a;
        it.operand_b     = in_ch.operand_b;
        it.operation     = in_ch.operation;
        it.dest_register = in_ch.dest_register;
        want = alu_predict(it, held_word);
        held_word = want.result;
        expected_results.push_back(want);
        instrs_taken++;
        in_fire = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        got.result            = out_ch.result;
        got.dest_register_out = out_ch.dest_register_out;
        got.bad_opcode        = out_ch.bad_opcode;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected transfer, result", got.result, '0);
        end else begin
          want = expected_results.pop_front();
          if (got.result !== want.result)
            report_mismatch("result", got.result, want.result);
          if (got.dest_register_out !== want.dest_register_out)
            report_mismatch("dest_register_out", 32'(got.dest_register_out),
                            32'(want.dest_register_out));
          if (got.bad_opcode !== want.bad_opcode)
            report_mismatch("bad_opcode", 32'(got.bad_opcode), 32'(want.bad_opcode));
        end
      end
    end
  end

  // input driver: bursts with random gaps
  always @(negedge clk) begin
    in_item_t it;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (pending_instrs.size() > 0) begin
        it = pending_instrs.pop_front();
        in_ch.operand_a     <= it.operand_a;
        in_ch.operand_b     <= it.operand_b;
        in_ch.operation     <= it.operation;
        in_ch.dest_register <= it.dest_register;
        in_ch.valid         <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 60);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
        end else begin
          burst_left--;
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // output sink: stall patterns plus one long hold
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (!long_hold_done && instrs_taken >= 700) begin
      long_hold_done = 1'b1;
      hold_left      = LongHold - 1;
      out_ch.ready  <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        sink_mode = sink_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(10, 80);
      end else begin
        mode_left--;
      end
      case (sink_mode)
        SINK_FREE: out_ch.ready <= 1'b1;
        SINK_HALF: out_ch.ready <= 1'($urandom_range(0, 1));
        default:   out_ch.ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    logic [WordW-1:0] a, b;
    logic [OpW-1:0]   op;
    in_ch.valid         = 1'b0;
    in_ch.operand_a     = '0;
    in_ch.operand_b     = '0;
    in_ch.operation     = OP_STALL;
    in_ch.dest_register = '0;
    out_ch.ready        = 1'b0;
    held_word           = '0;
    err_count           = 0;
    cycle_count         = 0;
    instrs_taken        = 0;
    in_fire             = 1'b0;
    burst_left          = 0;
    gap_left            = 0;
    hold_left           = 0;
    mode_left           = 0;
    long_hold_done      = 1'b0;
    sink_mode           = SINK_FREE;
    rst_n               = 1'b0;

    // stall right after reset repeats the cleared word
    add_instr(32'hffff_ffff, 32'hffff_ffff, OP_STALL, 5'd0);
    add_instr(32'hffff_ffff, 32'h0101_0101, OP_PADD, 5'd31);
    add_instr(32'h0000_00ff, 32'h0000_0001, OP_PADD, 5'd1);
    add_instr(32'hff80_7f01, 32'h0180_81ff, OP_PADDS, 5'd2);
    add_instr(32'hffff_ffff, 32'hffff_ffff, OP_PADDS, 5'd3);
    add_instr(32'h0000_0000, 32'h0000_0001, OP_PSUB, 5'd4);
    add_instr(32'h0000_0000, 32'hffff_ffff, OP_PSUB, 5'd5);
    add_instr(32'h00ff_0180, 32'hff00_0280, OP_PSUBS, 5'd6);
    add_instr(32'hffff_ffff, 32'h0000_0000, OP_PSUBS, 5'd7);
    add_instr(32'hffff_ffff, 32'hffff_ffff, OP_PMADD, 5'd8);
    add_instr(32'h0f10_0f10, 32'h1110_1110, OP_PMADD, 5'd9);
    add_instr(32'h0001_0203, 32'h0405_0607, OP_PMADD, 5'd10);
    add_instr(32'h1122_3344, 32'h5566_7788, OP_PACK, 5'd11);
    add_instr(32'hdead_beef, 32'hdead_beef, OP_CHROMA, 5'd12);
    add_instr(32'h00ff_1234, 32'h00fe_1235, OP_CHROMA, 5'd13);
    add_instr(32'h1234_5678, 32'h8765_4321, OP_STALL, 5'd30);
    for (int c = 0; c < 16; c++) begin
      if (!is_defined_op(4'(c)))
        add_instr(32'hcafe_f00d, 32'h0bad_beef, 4'(c), 5'(c + 14));
    end

    for (int n = 0; n < RandomItems; n++) begin
      op = rand_op();
      for (int i = 0; i < NLanes; i++) begin
        a[LaneW*i +: LaneW] = rand_lane();
        b[LaneW*i +: LaneW] = rand_lane();
      end
      // equal lanes feed the chroma compare and the zero-difference cases
      if (op == OP_CHROMA || $urandom_range(0, 3) == 0) begin
        for (int i = 0; i < NLanes; i++) begin
          if ($urandom_range(0, 1) == 1) b[LaneW*i +: LaneW] = a[LaneW*i +: LaneW];
        end
      end
      add_instr(a, b, op, 5'($urandom));
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (pending_instrs.size() > 0 || in_ch.valid) @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (err_count == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule : tb_top

// ===== sim.f =====
sv/pbsa_pkg.sv
sv/pbsa_if.sv
sv/pbsa_alu.sv
sv/packed_byte_simd_alu.sv
verif/tb_top.sv
